/* src/assert_macros.svh */
// Assertion macros for the checker file of the tree walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/nttw_pkg.sv */
// Types and constants shared by the nested TLV tree walker modules.
package nttw_pkg;

   localparam int unsigned HDR_BYTES = 2;

   typedef enum logic [1:0] {
      ROLE_HDR_HIGH = 2'd0,
      ROLE_HDR_LOW  = 2'd1,
      ROLE_PAYLOAD  = 2'd2,
      ROLE_IGNORED  = 2'd3
   } role_type;

   typedef enum logic [1:0] {
      KIND_STRING = 2'd0,
      KIND_LIST   = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      WALK_RUNNING   = 2'd0,
      WALK_DONE      = 2'd1,
      WALK_LEN_ERR   = 2'd2,
      WALK_DEPTH_ERR = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_HIGH    = 3'b001,
      PH_LOW     = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  byte_echo;
      role_type    byte_role;
      kind_type    node_kind;
      logic [1:0]  level;
      logic [14:0] element_length;
      logic        element_end;
      logic [1:0]  levels_closed;
      status_type  walk_status;
   } rsp_type;

endpackage

/* src/nttw_rsp_reg.sv */
// Result register with valid/ready handshake for the tree walker.
module nttw_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  nttw_pkg::rsp_type rsp_in,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output nttw_pkg::rsp_type rsp_data,
   output logic             can_load
);

   logic             valid_ff;
   logic             valid_in;
   nttw_pkg::rsp_type data_ff;

   // The register may be reloaded in the same cycle its content is taken.
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* src/nttw_core.sv */
// Walk state and per-byte decode logic of the nested TLV tree walker.
module nttw_core #(
   parameter int STACK_DEPTH = 4,
   parameter int LENGTH_BITS = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        data_byte,
   input  logic              first_byte,
   input  logic [15:0]       buffer_length,
   output nttw_pkg::rsp_type rsp_out
);

   localparam int DEPTH_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [15:0]            stack_ff [STACK_DEPTH];
   logic [15:0]            stack_in [STACK_DEPTH];
   logic [15:0]            eff_stack [STACK_DEPTH];
   logic [DEPTH_W-1:0]     depth_ff, depth_in, depth_a, eff_depth, deep_idx;
   nttw_pkg::phase_type    phase_ff, phase_in, phase_a, eff_phase;
   nttw_pkg::status_type   status_ff, status_in, status_a, eff_status;
   logic [7:0]             hi_ff, hi_in;
   logic [LENGTH_BITS-1:0] pl_ff, pl_in, pl_dec, elen_ff, elen_in, hdr_len;
   nttw_pkg::kind_type     kind_ff, kind_in, hdr_kind;
   logic [15:0]            hdr_word, cur_rem;
   logic [16:0]            need;
   logic                   too_long, too_deep, do_close, pop_found;
   logic [DEPTH_W-1:0]     pop_depth, pop_count;
   nttw_pkg::rsp_type      res;

   // A first byte restarts the walk with the whole buffer at level 0.
   always_comb begin
      for (int j = 0; j < STACK_DEPTH; j++) begin
         if (first_byte) begin
            eff_stack[j] = (j == 0) ? buffer_length : 16'd0;
         end else begin
            eff_stack[j] = stack_ff[j];
         end
      end
   end

   assign eff_depth  = first_byte ? '0 : depth_ff;
   assign eff_phase  = first_byte ? nttw_pkg::PH_HIGH : phase_ff;
   assign eff_status = first_byte ? nttw_pkg::WALK_RUNNING : status_ff;

   assign cur_rem  = eff_stack[eff_depth];
   assign hdr_word = {hi_ff, data_byte};
   assign hdr_len  = hdr_word[LENGTH_BITS-1:0];
   assign need     = 17'(hdr_len) + 17'(nttw_pkg::HDR_BYTES);
   assign too_long = need > {1'b0, cur_rem};
   assign too_deep = ({1'b0, eff_depth} + (DEPTH_W+1)'(1)) >= (DEPTH_W+1)'(STACK_DEPTH);
   assign deep_idx = eff_depth + DEPTH_W'(1);
   assign pl_dec   = pl_ff - LENGTH_BITS'(pl_ff != '0);

   always_comb begin
      if (!hi_ff[7]) begin
         hdr_kind = nttw_pkg::KIND_STRING;
      end else if (hdr_len != '0) begin
         hdr_kind = nttw_pkg::KIND_LIST;
      end else begin
         hdr_kind = nttw_pkg::KIND_EMPTY;
      end
   end

   // Decode of one byte, before exhausted levels are closed.
   always_comb begin
      stack_in = eff_stack;
      depth_a  = eff_depth;
      phase_a  = eff_phase;
      status_a = eff_status;
      hi_in    = hi_ff;
      pl_in    = first_byte ? '0 : pl_ff;
      kind_in  = first_byte ? nttw_pkg::KIND_STRING : kind_ff;
      elen_in  = first_byte ? '0 : elen_ff;
      do_close = 1'b0;
      res.byte_echo      = data_byte;
      res.byte_role      = nttw_pkg::ROLE_IGNORED;
      res.node_kind      = nttw_pkg::KIND_STRING;
      res.level          = 2'd0;
      res.element_length = 15'd0;
      res.element_end    = 1'b0;
      res.levels_closed  = 2'd0;
      res.walk_status    = nttw_pkg::WALK_RUNNING;
      if (eff_status == nttw_pkg::WALK_RUNNING) begin
         res.level = 2'(eff_depth);
         case (eff_phase)
            nttw_pkg::PH_HIGH: begin
               res.byte_role = nttw_pkg::ROLE_HDR_HIGH;
               hi_in = data_byte;
               if (cur_rem < 16'(nttw_pkg::HDR_BYTES)) begin
                  status_a = nttw_pkg::WALK_LEN_ERR;
               end else begin
                  phase_a = nttw_pkg::PH_LOW;
               end
            end
            nttw_pkg::PH_LOW: begin
               res.byte_role      = nttw_pkg::ROLE_HDR_LOW;
               res.node_kind      = hdr_kind;
               res.element_length = 15'(hdr_len);
               kind_in = hdr_kind;
               elen_in = hdr_len;
               if (too_long) begin
                  status_a = nttw_pkg::WALK_LEN_ERR;
               end else if (hdr_kind == nttw_pkg::KIND_LIST) begin
                  if (too_deep) begin
                     status_a = nttw_pkg::WALK_DEPTH_ERR;
                  end else begin
                     stack_in[eff_depth] = cur_rem - need[15:0];
                     stack_in[deep_idx]  = 16'(hdr_len);
                     depth_a = deep_idx;
                     phase_a = nttw_pkg::PH_HIGH;
                  end
               end else begin
                  stack_in[eff_depth] = cur_rem - need[15:0];
                  if (hdr_len == '0) begin
                     res.element_end = 1'b1;
                     do_close = 1'b1;
                  end else begin
                     pl_in   = hdr_len;
                     phase_a = nttw_pkg::PH_PAYLOAD;
                  end
               end
            end
            nttw_pkg::PH_PAYLOAD: begin
               res.byte_role      = nttw_pkg::ROLE_PAYLOAD;
               res.node_kind      = kind_ff;
               res.element_length = 15'(elen_ff);
               pl_in = pl_dec;
               if (pl_dec == '0) begin
                  res.element_end = 1'b1;
                  do_close = 1'b1;
               end
            end
            default: begin
               phase_a = nttw_pkg::PH_HIGH;
            end
         endcase
      end
   end

   // The deepest level at or above the current one that still has bytes left.
   always_comb begin
      pop_found = 1'b0;
      pop_depth = '0;
      for (int j = 0; j < STACK_DEPTH; j++) begin
         if ((DEPTH_W'(j) <= eff_depth) && (stack_in[j] != 16'd0)) begin
            pop_found = 1'b1;
            pop_depth = DEPTH_W'(j);
         end
      end
   end

   assign pop_count = eff_depth - pop_depth;

   always_comb begin
      depth_in  = depth_a;
      phase_in  = phase_a;
      status_in = status_a;
      if (do_close) begin
         depth_in = pop_depth;
         phase_in = nttw_pkg::PH_HIGH;
         if (!pop_found) begin
            status_in = nttw_pkg::WALK_DONE;
         end
      end
   end

   always_comb begin
      rsp_out               = res;
      rsp_out.levels_closed = do_close ? 2'(pop_count) : 2'd0;
      rsp_out.walk_status   = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < STACK_DEPTH; j++) begin
            stack_ff[j] <= 16'd0;
         end
         depth_ff  <= '0;
         phase_ff  <= nttw_pkg::PH_HIGH;
         status_ff <= nttw_pkg::WALK_DONE;
         hi_ff     <= 8'd0;
         pl_ff     <= '0;
         kind_ff   <= nttw_pkg::KIND_STRING;
         elen_ff   <= '0;
      end else if (step_en) begin
         stack_ff  <= stack_in;
         depth_ff  <= depth_in;
         phase_ff  <= phase_in;
         status_ff <= status_in;
         hi_ff     <= hi_in;
         pl_ff     <= pl_in;
         kind_ff   <= kind_in;
         elen_ff   <= elen_in;
      end
   end

endmodule

/* src/nested_tlv_tree_walker.sv */
// Top level of the nested TLV tree walker: byte decoder plus result register.
//
//   Channel   Handshake              Payload
//   req       req_valid/req_ready    req_data_byte, req_first_byte, req_buffer_length
//   rsp       rsp_valid/rsp_ready    rsp_byte_echo ... rsp_walk_status (eight fields)
//
// Every accepted byte yields exactly one result, registered for the next cycle.
// Throughput is one byte per cycle unless rsp stalls: the walk state is read
// and written by combinational decode logic, and the result register is
// refilled in the cycle its content is taken. A stalled rsp side holds
// req_ready low until the waiting result transfers. Reset leaves the walk
// finished, so bytes are reported as ignored until a first byte starts a buffer.
module nested_tlv_tree_walker #(
   parameter int STACK_DEPTH = 4,
   parameter int LENGTH_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [15:0] req_buffer_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_echo,
   output logic [1:0]  rsp_byte_role,
   output logic [1:0]  rsp_node_kind,
   output logic [1:0]  rsp_level,
   output logic [14:0] rsp_element_length,
   output logic        rsp_element_end,
   output logic [1:0]  rsp_levels_closed,
   output logic [1:0]  rsp_walk_status
);

   logic              req_xfer;
   logic              can_load;
   nttw_pkg::rsp_type step_rsp;
   nttw_pkg::rsp_type rsp_data;

   // A request transfers whenever the result register is free or draining.
   assign req_ready = can_load;
   assign req_xfer  = req_valid && can_load;

   // Decoder: the walk state advances only on a request transfer.
   nttw_core #(
      .STACK_DEPTH (STACK_DEPTH),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (req_xfer),
      .data_byte     (req_data_byte),
      .first_byte    (req_first_byte),
      .buffer_length (req_buffer_length),
      .rsp_out       (step_rsp)
   );

   // Result register that separates the two handshakes.
   nttw_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_xfer),
      .rsp_in    (step_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_load  (can_load)
   );

   assign rsp_byte_echo      = rsp_data.byte_echo;
   assign rsp_byte_role      = rsp_data.byte_role;
   assign rsp_node_kind      = rsp_data.node_kind;
   assign rsp_level          = rsp_data.level;
   assign rsp_element_length = rsp_data.element_length;
   assign rsp_element_end    = rsp_data.element_end;
   assign rsp_levels_closed  = rsp_data.levels_closed;
   assign rsp_walk_status    = rsp_data.walk_status;

endmodule

/* src/nttw_checker.sv */
// Port-level checker for the nested TLV tree walker, bound to the top level.
`include "assert_macros.svh"

module nttw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        req_first_byte,
   input logic [15:0] req_buffer_length,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_byte_echo,
   input logic [1:0]  rsp_byte_role,
   input logic [1:0]  rsp_node_kind,
   input logic [1:0]  rsp_level,
   input logic [14:0] rsp_element_length,
   input logic        rsp_element_end,
   input logic [1:0]  rsp_levels_closed,
   input logic [1:0]  rsp_walk_status
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_byte_echo) && $stable(rsp_walk_status), "result changed while stalled")
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with an empty result register")
   `ASSERT_NEXT(a_one_result, clock, reset, req_valid && req_ready, rsp_valid && rsp_byte_echo == $past(req_data_byte), "transfer did not produce its result")
   `ASSERT_SAME(a_ignored_clean, clock, reset, rsp_valid && rsp_byte_role == nttw_pkg::ROLE_IGNORED, rsp_walk_status != nttw_pkg::WALK_RUNNING && rsp_level == 2'd0 && rsp_element_length == 15'd0 && !rsp_element_end && rsp_levels_closed == 2'd0, "ignored byte carries walk data")

endmodule

bind nested_tlv_tree_walker nttw_checker u_nttw_checker (.*);
